>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the two-wire ADC serial master.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset is released.
`define TWADC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TWADC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/twadc_pkg.sv
// Types, constants and register codes for the two-wire ADC serial master.
// No dependencies; used by every RTL module and interface.
package twadc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SHIFT_W     = (SAMPLE_BITS > 8) ? SAMPLE_BITS : 8;
  localparam int SAMPLE_W    = 24;
  localparam int CONFIG_W    = 8;
  localparam int HP_W        = 10;
  localparam int POLL_W      = 8;
  localparam int BIT_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0]          READ_CMD   = 7'h56;
  localparam logic [6:0]          WRITE_CMD  = 7'h65;
  localparam logic [CONFIG_W-1:0] WR_MASK    = 8'hEF;

  // Pulse numbers of the conversion frame and the register read/write frame.
  localparam logic [BIT_W-1:0] REG_PULSES  = BIT_W'(46);
  localparam logic [BIT_W-1:0] CONV_PULSES = BIT_W'(SAMPLE_BITS + 3);
  localparam logic [BIT_W-1:0] CONV_LAST   = BIT_W'(SAMPLE_BITS);
  localparam logic [BIT_W-1:0] DRV_PULSE   = BIT_W'(27);
  localparam logic [BIT_W-1:0] CMD_FIRST   = BIT_W'(29);
  localparam logic [BIT_W-1:0] CMD_LAST    = BIT_W'(35);
  localparam logic [BIT_W-1:0] RD_RELEASE  = BIT_W'(36);
  localparam logic [BIT_W-1:0] RD_FIRST    = BIT_W'(38);
  localparam logic [BIT_W-1:0] RD_LAST     = BIT_W'(45);
  localparam logic [BIT_W-1:0] WR_FIRST    = BIT_W'(37);
  localparam logic [BIT_W-1:0] WR_LAST     = BIT_W'(44);
  localparam logic [BIT_W-1:0] WR_RELEASE  = BIT_W'(45);

  // Register reset values
  localparam logic [HP_W-1:0]   HALF_PERIOD_RST = 10'd10;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST  = 8'd5;
  localparam logic [HP_W-1:0]   POLL_GAP_RST    = 10'd5;
  localparam logic              IDLE_CLK_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_POLL_LIMIT  = 2'd1,
    CFG_POLL_GAP    = 2'd2,
    CFG_IDLE_CLOCK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CONV  = 2'd1,
    OP_RDREG = 2'd2,
    OP_WRREG = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_POLL   = 5'b00010,
    PH_HIGH   = 5'b00100,
    PH_LOW    = 5'b01000,
    PH_FINISH = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [HP_W-1:0]   half_period;
    logic [POLL_W-1:0] poll_limit;
    logic [HP_W-1:0]   poll_gap;
    logic              idle_clock_high;
  } cfg_t;

  // Classified tick as held in the queue
  typedef struct packed {
    op_t                 op;
    logic [CONFIG_W-1:0] wbyte;
    logic                dl;
  } item_t;

endpackage

>>> rtl/twadc_if.sv
// Valid/ready channel interfaces for the two-wire ADC serial master.
// Depends on twadc_pkg for field widths.
interface twadc_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [twadc_pkg::CONFIG_W-1:0] write_value;
  logic                           data_level;

  modport source (output valid, output op, output write_value, output data_level,
                  input ready);
  modport sink (input valid, input op, input write_value, input data_level,
                output ready);
endinterface

interface twadc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           clock_level;
  logic                           data_drive;
  logic                           data_out;
  logic                           busy_res;
  logic                           done_res;
  logic                           status;
  logic [twadc_pkg::SAMPLE_W-1:0] sample;
  logic [twadc_pkg::CONFIG_W-1:0] config_read;

  modport source (output valid, output clock_level, output data_drive, output data_out,
                  output busy_res, output done_res, output status, output sample,
                  output config_read, input ready);
  modport sink (input valid, input clock_level, input data_drive, input data_out,
                input busy_res, input done_res, input status, input sample,
                input config_read, output ready);
endinterface

>>> rtl/twadc_front.sv
// Front end: accepts ticks, decodes the op and masks the write byte,
// and queues them for the sequencer. Depends on twadc_pkg, twadc_if.
`include "assert_macros.svh"

module twadc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  twadc_in_if.sink             in_chan,
  output logic                 q_valid,
  output twadc_pkg::item_t     q_item,
  input  logic                 q_pop
);

  twadc_pkg::item_t                  q_mem_r [twadc_pkg::QUEUE_DEPTH];
  logic [twadc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [twadc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [twadc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              push;
  twadc_pkg::item_t                  item_in;

  assign in_chan.ready = (cnt_r != twadc_pkg::QCNT_W'(twadc_pkg::QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (cnt_r != '0);
  assign q_item        = q_mem_r[rd_ptr_r];

  // classify: typed op, write byte with bit 4 cleared
  always_comb begin
    item_in.op    = twadc_pkg::op_t'(in_chan.op);
    item_in.wbyte = in_chan.write_value & twadc_pkg::WR_MASK;
    item_in.dl    = in_chan.data_level;
  end

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + twadc_pkg::QCNT_W'(push) - twadc_pkg::QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  `TWADC_ASSERT(a_pop_nonempty, q_pop |-> (cnt_r != '0), "pop from empty queue")
  `TWADC_ASSERT(a_cnt_range, cnt_r <= twadc_pkg::QCNT_W'(twadc_pkg::QUEUE_DEPTH), "queue overflow")
  `TWADC_ASSERT(a_cnt_track, (push && !q_pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count lost a push")

endmodule

>>> rtl/twadc_core.sv
// Back end: pin sequencer for the two-wire link, one tick per queued item,
// with a registered result stage. Depends on twadc_pkg, twadc_if.
`include "assert_macros.svh"

module twadc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  twadc_pkg::cfg_t      cfg,
  input  logic                 q_valid,
  input  twadc_pkg::item_t     q_item,
  output logic                 q_pop,
  twadc_out_if.source          out_chan
);

  twadc_pkg::phase_t                 phase_r, phase_nxt;
  twadc_pkg::op_t                    pend_r, pend_nxt;
  logic [twadc_pkg::BIT_W-1:0]       bit_r, bit_nxt;
  logic [twadc_pkg::HP_W-1:0]        tick_r, tick_nxt;
  logic [twadc_pkg::POLL_W-1:0]      poll_r, poll_nxt;
  logic [twadc_pkg::SHIFT_W-1:0]     ishift_r, ishift_nxt;
  logic [twadc_pkg::CONFIG_W-1:0]    oshift_r, oshift_nxt;
  logic                              clk_pin_r, clk_pin_nxt;
  logic                              drive_r, drive_nxt;
  logic                              dout_r, dout_nxt;
  logic [twadc_pkg::SAMPLE_W-1:0]    sample_r, sample_nxt;
  logic [twadc_pkg::CONFIG_W-1:0]    cfgrd_r, cfgrd_nxt;
  logic                              busy, done, status;

  logic                              out_valid_r;
  logic                              res_busy_r, res_done_r, res_status_r;
  logic                              res_clk_r, res_drive_r, res_dout_r;
  logic [twadc_pkg::SAMPLE_W-1:0]    res_sample_r;
  logic [twadc_pkg::CONFIG_W-1:0]    res_cfgrd_r;

  logic [twadc_pkg::HP_W-1:0]        hp, gap;
  logic [twadc_pkg::POLL_W-1:0]      limit;
  logic [twadc_pkg::BIT_W-1:0]       last;
  logic [twadc_pkg::HP_W:0]          tick_inc;
  logic [twadc_pkg::POLL_W:0]        poll_inc;
  logic [6:0]                        cmd;
  logic [2:0]                        cmd_idx, wr_idx;
  logic                              dl;

  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);
  assign dl    = q_item.dl;

  always_comb begin
    hp       = (cfg.half_period == '0) ? twadc_pkg::HP_W'(1) : cfg.half_period;
    gap      = (cfg.poll_gap == '0) ? twadc_pkg::HP_W'(1) : cfg.poll_gap;
    limit    = (cfg.poll_limit == '0) ? twadc_pkg::POLL_W'(1) : cfg.poll_limit;
    last     = (pend_r == twadc_pkg::OP_CONV) ? twadc_pkg::CONV_PULSES
                                              : twadc_pkg::REG_PULSES;
    tick_inc = {1'b0, tick_r} + 1'b1;
    poll_inc = {1'b0, poll_r} + 1'b1;
    cmd      = (pend_r == twadc_pkg::OP_RDREG) ? twadc_pkg::READ_CMD
                                               : twadc_pkg::WRITE_CMD;
    cmd_idx  = 3'(twadc_pkg::CMD_LAST - bit_r);
    wr_idx   = 3'(twadc_pkg::WR_LAST - bit_r);
  end

  // one tick of the pin sequencer
  always_comb begin
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    bit_nxt     = bit_r;
    tick_nxt    = tick_r;
    poll_nxt    = poll_r;
    ishift_nxt  = ishift_r;
    oshift_nxt  = oshift_r;
    clk_pin_nxt = clk_pin_r;
    drive_nxt   = drive_r;
    dout_nxt    = dout_r;
    sample_nxt  = sample_r;
    cfgrd_nxt   = cfgrd_r;
    busy        = 1'b1;
    done        = 1'b0;
    status      = 1'b0;

    unique case (phase_r)
      twadc_pkg::PH_IDLE: begin
        if (q_item.op == twadc_pkg::OP_NONE) begin
          busy = 1'b0;
        end else begin
          pend_nxt    = q_item.op;
          bit_nxt     = '0;
          tick_nxt    = '0;
          poll_nxt    = '0;
          ishift_nxt  = '0;
          clk_pin_nxt = 1'b0;
          if (q_item.op == twadc_pkg::OP_CONV) begin
            drive_nxt = 1'b0;
            phase_nxt = twadc_pkg::PH_POLL;
          end else begin
            oshift_nxt = (q_item.op == twadc_pkg::OP_WRREG) ? q_item.wbyte : '0;
            bit_nxt    = twadc_pkg::BIT_W'(1);
            phase_nxt  = twadc_pkg::PH_HIGH;
          end
        end
      end
      twadc_pkg::PH_POLL: begin
        if (tick_r != '0) begin
          tick_nxt = tick_r - 1'b1;
        end else if (!dl) begin
          bit_nxt   = twadc_pkg::BIT_W'(1);
          phase_nxt = twadc_pkg::PH_HIGH;
        end else if (poll_inc >= {1'b0, limit}) begin
          done      = 1'b1;
          status    = 1'b1;
          phase_nxt = twadc_pkg::PH_IDLE;
        end else begin
          poll_nxt = poll_r + 1'b1;
          tick_nxt = gap - 1'b1;
        end
      end
      twadc_pkg::PH_HIGH: begin
        clk_pin_nxt = 1'b1;
        if (tick_inc >= {1'b0, hp}) begin
          phase_nxt = twadc_pkg::PH_LOW;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[twadc_pkg::HP_W-1:0];
        end
      end
      twadc_pkg::PH_LOW: begin
        clk_pin_nxt = 1'b0;
        // falling edge: sample data, set up data for the next pulse
        if (tick_r == '0) begin
          if (pend_r == twadc_pkg::OP_CONV) begin
            if (bit_r <= twadc_pkg::CONV_LAST) begin
              ishift_nxt = {ishift_r[twadc_pkg::SHIFT_W-2:0], dl};
            end
          end else if (bit_r == twadc_pkg::DRV_PULSE) begin
            drive_nxt = 1'b1;
            dout_nxt  = 1'b1;
          end else if (bit_r >= twadc_pkg::CMD_FIRST && bit_r <= twadc_pkg::CMD_LAST) begin
            dout_nxt = cmd[cmd_idx];
          end else if (pend_r == twadc_pkg::OP_RDREG) begin
            if (bit_r == twadc_pkg::RD_RELEASE) begin
              drive_nxt = 1'b0;
            end else if (bit_r >= twadc_pkg::RD_FIRST && bit_r <= twadc_pkg::RD_LAST) begin
              ishift_nxt = {ishift_r[twadc_pkg::SHIFT_W-2:0], dl};
            end
          end else begin
            if (bit_r >= twadc_pkg::WR_FIRST && bit_r <= twadc_pkg::WR_LAST) begin
              dout_nxt = oshift_r[wr_idx];
            end else if (bit_r == twadc_pkg::WR_RELEASE) begin
              drive_nxt = 1'b0;
            end
          end
        end
        if (tick_inc >= {1'b0, hp}) begin
          tick_nxt = '0;
          if (bit_r >= last) begin
            phase_nxt = twadc_pkg::PH_FINISH;
          end else begin
            bit_nxt   = bit_r + 1'b1;
            phase_nxt = twadc_pkg::PH_HIGH;
          end
        end else begin
          tick_nxt = tick_inc[twadc_pkg::HP_W-1:0];
        end
      end
      twadc_pkg::PH_FINISH: begin
        done = 1'b1;
        if (pend_r == twadc_pkg::OP_CONV) begin
          sample_nxt = twadc_pkg::SAMPLE_W'(ishift_r);
          drive_nxt  = 1'b1;
          dout_nxt   = 1'b1;
        end else if (pend_r == twadc_pkg::OP_RDREG) begin
          cfgrd_nxt = ishift_r[twadc_pkg::CONFIG_W-1:0];
        end
        phase_nxt = twadc_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = twadc_pkg::PH_IDLE;
      end
    endcase

    if (phase_nxt == twadc_pkg::PH_IDLE) begin
      clk_pin_nxt = cfg.idle_clock_high;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= twadc_pkg::PH_IDLE;
      pend_r      <= twadc_pkg::OP_NONE;
      bit_r       <= '0;
      tick_r      <= '0;
      poll_r      <= '0;
      ishift_r    <= '0;
      oshift_r    <= '0;
      clk_pin_r   <= twadc_pkg::IDLE_CLK_RST;
      drive_r     <= 1'b0;
      dout_r      <= 1'b0;
      sample_r    <= '0;
      cfgrd_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r   <= phase_nxt;
        pend_r    <= pend_nxt;
        bit_r     <= bit_nxt;
        tick_r    <= tick_nxt;
        poll_r    <= poll_nxt;
        ishift_r  <= ishift_nxt;
        oshift_r  <= oshift_nxt;
        clk_pin_r <= clk_pin_nxt;
        drive_r   <= drive_nxt;
        dout_r    <= dout_nxt;
        sample_r  <= sample_nxt;
        cfgrd_r   <= cfgrd_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded with each tick's outcome
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_clk_r    <= clk_pin_nxt;
      res_drive_r  <= drive_nxt;
      res_dout_r   <= dout_nxt;
      res_busy_r   <= busy;
      res_done_r   <= done;
      res_status_r <= status;
      res_sample_r <= sample_nxt;
      res_cfgrd_r  <= cfgrd_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.clock_level = res_clk_r;
  assign out_chan.data_drive  = res_drive_r;
  assign out_chan.data_out    = res_dout_r;
  assign out_chan.busy_res    = res_busy_r;
  assign out_chan.done_res    = res_done_r;
  assign out_chan.status      = res_status_r;
  assign out_chan.sample      = res_sample_r;
  assign out_chan.config_read = res_cfgrd_r;

  `TWADC_ASSERT(a_done_busy, (q_pop && done) |-> busy, "done without busy")
  `TWADC_ASSERT(a_finish_idle, (q_pop && phase_r == twadc_pkg::PH_FINISH) |=> (phase_r == twadc_pkg::PH_IDLE), "finish did not return to idle")
  `TWADC_ASSERT(a_status_conv, (q_pop && status) |-> (pend_r == twadc_pkg::OP_CONV && phase_r == twadc_pkg::PH_POLL), "timeout outside conversion poll")

endmodule

>>> rtl/two_wire_adc_serial_master.sv
// Two-wire ADC serial master: one input item is one tick of the pin sequencer.
// An accepted item's result is registered: it passes the queue, then the result register.
// Throughput: 1 item per cycle while the output is not stalled; one sequencer step per item from the 2-entry queue.
// Either side may stall on its own: the queue absorbs input, the result register holds output.
// Reset (synchronous, rst_n low): queue empty, sequencer idle, clock pin high, data released,
// registers back to half_period 10, poll_limit 5, poll_gap 5, idle clock high.
// Depends on twadc_pkg, twadc_if, twadc_front, twadc_core.

module two_wire_adc_serial_master (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [twadc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twadc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  twadc_in_if.sink                         in_chan,
  twadc_out_if.source                      out_chan
);

  // Configuration registers. The user must make writes land only while the link is idle;
  // the block does not enforce it. The sequencer reads them directly without shadowing.
  twadc_pkg::cfg_t  cfg_r, cfg_nxt;

  // Queue between the front (accept/classify) and the back (sequencer)
  logic              q_valid;
  logic              q_pop;
  twadc_pkg::item_t  q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (twadc_pkg::cfg_idx_t'(cfg_index))
        twadc_pkg::CFG_HALF_PERIOD: cfg_nxt.half_period     = cfg_wdata[twadc_pkg::HP_W-1:0];
        twadc_pkg::CFG_POLL_LIMIT:  cfg_nxt.poll_limit      = cfg_wdata[twadc_pkg::POLL_W-1:0];
        twadc_pkg::CFG_POLL_GAP:    cfg_nxt.poll_gap        = cfg_wdata[twadc_pkg::HP_W-1:0];
        twadc_pkg::CFG_IDLE_CLOCK:  cfg_nxt.idle_clock_high = cfg_wdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period     <= twadc_pkg::HALF_PERIOD_RST;
      cfg_r.poll_limit      <= twadc_pkg::POLL_LIMIT_RST;
      cfg_r.poll_gap        <= twadc_pkg::POLL_GAP_RST;
      cfg_r.idle_clock_high <= twadc_pkg::IDLE_CLK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: takes ticks, decodes op, clears bit 4 of the write byte, queues.
  twadc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back: poll / clock / shift sequencer plus the result register.
  twadc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

>>> verif/tb_two_wire_adc_serial_master.sv
// Testbench for the two-wire ADC serial master: ticks in, pin/status results out.
// Checks every result against an in-bench sequencer predictor, under random idling.
// Depends on twadc_pkg and the twadc_in_if / twadc_out_if interfaces of the RTL.

module tb_two_wire_adc_serial_master;
  timeunit 1ns;
  timeprecision 1ps;

  import twadc_pkg::*;

  // Expected result of one tick, field for field as on the output channel
  typedef struct packed {
    logic                clock_level;
    logic                data_drive;
    logic                data_out;
    logic                busy_res;
    logic                done_res;
    logic                status;
    logic [SAMPLE_W-1:0] sample;
    logic [CONFIG_W-1:0] config_read;
  } pin_result_t;

  // Level pattern put on the data pin while bits are shifted in
  typedef enum int {BITS_RANDOM, BITS_ONES, BITS_ZEROS} bits_t;

  // Receiver ready patterns
  typedef enum int {RX_OPEN, RX_DENSE, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // Rough number of input items for the whole run
  localparam int unsigned ITEM_BUDGET = 950;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  twadc_in_if  in_if();
  twadc_out_if out_if();

  two_wire_adc_serial_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // ---------------------------------------------------------------------------
  // Sequencer predictor: register copies and state
  // ---------------------------------------------------------------------------
  logic [HP_W-1:0]   hp_reg;
  logic [POLL_W-1:0] limit_reg;
  logic [HP_W-1:0]   gap_reg;
  logic              idle_clk_reg;

  phase_t             seq_phase;
  op_t                cur_op;
  int unsigned        pulse;      // clock pulse number within the frame, from 1
  int unsigned        ticks;      // ticks spent in the current clock phase / left in the poll wait
  int unsigned        polls;      // failed ready checks so far
  logic [SHIFT_W-1:0] shift_in;
  logic [7:0]         shift_out;
  logic               clk_pin, drv_pin, dout_pin;
  logic [SAMPLE_W-1:0] sample_reg;
  logic [CONFIG_W-1:0] config_reg;

  item_t       tick_q[$];         // ticks waiting for the driver
  pin_result_t expected_pins[$];  // predicted results not yet seen
  int unsigned ticks_queued;
  int unsigned mismatches;

  // Zero in half_period, poll_limit or poll_gap behaves as one
  function automatic int unsigned at_least_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void reset_predictor();
    hp_reg       = HALF_PERIOD_RST;
    limit_reg    = POLL_LIMIT_RST;
    gap_reg      = POLL_GAP_RST;
    idle_clk_reg = IDLE_CLK_RST;
    seq_phase    = PH_IDLE;
    cur_op       = OP_NONE;
    pulse        = 0;
    ticks        = 0;
    polls        = 0;
    shift_in     = '0;
    shift_out    = '0;
    clk_pin      = IDLE_CLK_RST;
    drv_pin      = 1'b0;
    dout_pin     = 1'b0;
    sample_reg   = '0;
    config_reg   = '0;
  endfunction

  // First low tick of a pulse: sample the pin and set up data for the next pulse
  function automatic void sample_edge(input logic dl);
    int unsigned p;
    logic [6:0]  cmd;
    p   = pulse;
    cmd = (cur_op == OP_RDREG) ? READ_CMD : WRITE_CMD;
    if (cur_op == OP_CONV) begin
      // pulses 1..24 carry the code, the three trailing pulses carry nothing
      if (p <= SAMPLE_BITS) shift_in = {shift_in[SHIFT_W-2:0], dl};
    end else if (p == DRV_PULSE) begin
      drv_pin  = 1'b1;
      dout_pin = 1'b1;
    end else if (p >= CMD_FIRST && p <= CMD_LAST) begin
      dout_pin = cmd[CMD_LAST - p];
    end else if (cur_op == OP_RDREG) begin
      if (p == RD_RELEASE) drv_pin = 1'b0;
      else if (p >= RD_FIRST && p <= RD_LAST)
        shift_in = {{(SHIFT_W-8){1'b0}}, shift_in[6:0], dl};
    end else begin
      if (p >= WR_FIRST && p <= WR_LAST) dout_pin = shift_out[WR_LAST - p];
      else if (p == WR_RELEASE) drv_pin = 1'b0;
    end
  endfunction

  // One tick of the sequencer; returns the result the block must give for it
  function automatic pin_result_t step_sequencer(input item_t it);
    pin_result_t r;
    int unsigned hp, lim, gap, last;
    logic        done, stat, busy;
    hp   = at_least_one(hp_reg);
    lim  = at_least_one(limit_reg);
    gap  = at_least_one(gap_reg);
    last = (cur_op == OP_CONV) ? CONV_PULSES : REG_PULSES;
    done = 1'b0;
    stat = 1'b0;
    busy = 1'b1;
    case (seq_phase)
      PH_IDLE: begin
        if (it.op == OP_NONE) begin
          busy = 1'b0;
        end else begin
          cur_op   = it.op;
          pulse    = 0;
          ticks    = 0;
          polls    = 0;
          shift_in = '0;
          clk_pin  = 1'b0;
          if (it.op == OP_CONV) begin
            drv_pin   = 1'b0;
            seq_phase = PH_POLL;
          end else begin
            shift_out = (it.op == OP_WRREG) ? (it.wbyte & WR_MASK) : '0;
            pulse     = 1;
            seq_phase = PH_HIGH;
          end
        end
      end
      PH_POLL: begin
        if (ticks != 0) begin
          ticks--;
        end else if (!it.dl) begin
          // converter pulls data low when the code is ready
          pulse     = 1;
          seq_phase = PH_HIGH;
        end else if (polls + 1 >= lim) begin
          done      = 1'b1;
          stat      = 1'b1;
          seq_phase = PH_IDLE;
        end else begin
          polls++;
          ticks = gap - 1;
        end
      end
      PH_HIGH: begin
        clk_pin = 1'b1;
        if (ticks + 1 >= hp) begin
          seq_phase = PH_LOW;
          ticks     = 0;
        end else begin
          ticks++;
        end
      end
      PH_LOW: begin
        clk_pin = 1'b0;
        if (ticks == 0) sample_edge(it.dl);
        if (ticks + 1 >= hp) begin
          ticks = 0;
          if (pulse >= last) begin
            seq_phase = PH_FINISH;
          end else begin
            pulse++;
            seq_phase = PH_HIGH;
          end
        end else begin
          ticks++;
        end
      end
      default: begin
        done = 1'b1;
        if (cur_op == OP_CONV) begin
          sample_reg = shift_in[SAMPLE_W-1:0];
          drv_pin    = 1'b1;
          dout_pin   = 1'b1;
        end else if (cur_op == OP_RDREG) begin
          config_reg = shift_in[CONFIG_W-1:0];
        end
        seq_phase = PH_IDLE;
      end
    endcase
    // idle clock level shows at once, also on the done tick
    if (seq_phase == PH_IDLE) clk_pin = idle_clk_reg;
    r.clock_level = clk_pin;
    r.data_drive  = drv_pin;
    r.data_out    = dout_pin;
    r.busy_res    = busy;
    r.done_res    = done;
    r.status      = stat;
    r.sample      = sample_reg;
    r.config_read = config_reg;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_tick(input item_t t);
    tick_q.push_back(t);
    ticks_queued++;
  endfunction

  // Ticks with no op; pin level and write byte are don't-care but random
  function automatic void queue_idle(input int unsigned n);
    item_t t;
    repeat (n) begin
      t.op    = OP_NONE;
      t.wbyte = 8'($urandom);
      t.dl    = 1'($urandom);
      push_tick(t);
    end
  endfunction

  // One well-formed transaction: the op tick and every tick up to its done tick.
  // For a conversion read, 'fails' ready checks fail first; fails >= poll_limit
  // makes it time out. Ops on later ticks land while busy and must be ignored.
  function automatic void queue_transaction(input op_t op, input logic [7:0] wv,
                                            input int unsigned fails, input bits_t pattern);
    int unsigned hp, lim, gap, ready_at, last_tick;
    item_t t;
    hp       = at_least_one(hp_reg);
    lim      = at_least_one(limit_reg);
    gap      = at_least_one(gap_reg);
    ready_at = 0;
    if (op == OP_CONV && fails >= lim) begin
      last_tick = 1 + (lim - 1) * gap;
    end else if (op == OP_CONV) begin
      ready_at  = 1 + fails * gap;
      last_tick = ready_at + 2 * CONV_PULSES * hp + 1;
    end else begin
      last_tick = 2 * REG_PULSES * hp + 1;
    end
    t.op    = op;
    t.wbyte = wv;
    t.dl    = 1'($urandom);
    push_tick(t);
    for (int unsigned k = 1; k <= last_tick; k++) begin
      t.op    = ($urandom_range(0, 9) == 0) ? op_t'($urandom_range(1, 3)) : OP_NONE;
      t.wbyte = 8'($urandom);
      case (pattern)
        BITS_ONES:  t.dl = 1'b1;
        BITS_ZEROS: t.dl = 1'b0;
        default:    t.dl = 1'($urandom);
      endcase
      // ready checks fall every poll_gap ticks after the op tick
      if (op == OP_CONV && (ready_at == 0 || k <= ready_at) && (k - 1) % gap == 0)
        t.dl = (k != ready_at);
      push_tick(t);
    end
  endfunction

  // Fully random ticks, then enough quiet ticks for any started frame to end
  function automatic void queue_noise(input int unsigned n);
    item_t t;
    int unsigned drain;
    drain = 2 * REG_PULSES * at_least_one(hp_reg)
          + at_least_one(limit_reg) * at_least_one(gap_reg) + 4;
    repeat (n) begin
      t.op    = op_t'($urandom_range(0, 3));
      t.wbyte = 8'($urandom);
      t.dl    = 1'($urandom);
      push_tick(t);
    end
    queue_idle(drain);
  endfunction

  // Everything sent and answered, then an idle margin for the result register
  task automatic wait_drained();
    do @(posedge clk);
    while (tick_q.size() != 0 || in_if.valid || expected_pins.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back while the block is idle
  task automatic load_config(input logic [HP_W-1:0] hp, input logic [POLL_W-1:0] lim,
                             input logic [HP_W-1:0] gap, input logic idle_hi);
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_t'(i);
      case (idx)
        CFG_HALF_PERIOD: val = CFG_DATA_W'(hp);
        CFG_POLL_LIMIT:  val = CFG_DATA_W'(lim);
        CFG_POLL_GAP:    val = CFG_DATA_W'(gap);
        default:         val = CFG_DATA_W'(idle_hi);
      endcase
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
    end
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    hp_reg       = hp;
    limit_reg    = lim;
    gap_reg      = gap;
    idle_clk_reg = idle_hi;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Time limit: a run is about 1k ticks plus one long receiver hold;
  // the limit is many times that
  initial begin
    #400_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: sends queued ticks in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  item_t       drv_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        drv_item = tick_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.op          <= drv_item.op;
        in_if.write_value <= drv_item.wbyte;
        in_if.data_level  <= drv_item.dl;
        if (burst_left <= 1) begin
          // now and then a long burst with no gaps at all
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                   : $urandom_range(1, 40);
          gap_left   = $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall patterns, plus one long hold-off to back up the input
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_taken;
  int unsigned rx_hold_left;
  bit          rx_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode      = RX_OPEN;
      rx_mode_left = 100;
      rx_taken     = 0;
      rx_hold_left = 0;
      rx_hold_done = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) rx_taken++;
      if (!rx_hold_done && rx_taken >= 400) begin
        rx_hold_done = 1'b1;
        rx_hold_left = 300;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_DENSE:  out_if.ready <= ($urandom_range(0, 9) != 0);
          RX_SPARSE: out_if.ready <= 1'($urandom);
          default:   out_if.ready <= (rx_mode_left % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted tick, check every accepted result
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  pin_result_t mon_want;
  item_t       mon_item;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pins.size() == 0) begin
          $error("result with no tick outstanding");
          mismatches++;
        end else begin
          mon_want = expected_pins.pop_front();
          check_field("clock_level", mon_want.clock_level, out_if.clock_level);
          check_field("data_drive",  mon_want.data_drive,  out_if.data_drive);
          check_field("data_out",    mon_want.data_out,    out_if.data_out);
          check_field("busy_res",    mon_want.busy_res,    out_if.busy_res);
          check_field("done_res",    mon_want.done_res,    out_if.done_res);
          check_field("status",      mon_want.status,      out_if.status);
          check_field("sample",      mon_want.sample,      out_if.sample);
          check_field("config_read", mon_want.config_read, out_if.config_read);
        end
      end
      if (in_if.valid && in_if.ready) begin
        mon_item.op    = op_t'(in_if.op);
        mon_item.wbyte = in_if.write_value;
        mon_item.dl    = in_if.data_level;
        expected_pins.push_back(step_sequencer(mon_item));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [HP_W-1:0]   r_hp, r_gap;
    logic [POLL_W-1:0] r_lim;

    in_if.valid       = 1'b0;
    in_if.op          = OP_NONE;
    in_if.write_value = '0;
    in_if.data_level  = 1'b0;
    out_if.ready      = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_HALF_PERIOD;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    ticks_queued      = 0;
    mismatches        = 0;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a conversion read that times out after five checks
    queue_idle(3);
    queue_transaction(OP_CONV, 8'h00, 5, BITS_ONES);
    queue_idle(2);

    // Fastest clock, single ready check, idle clock low: timeout on the only
    // check, an all-ones code, a write of 0x10 whose bit 4 is masked off, starting from
    // data driven high, an all-zero read, then raw noise
    load_config(10'd1, 8'd1, 10'd1, 1'b0);
    queue_idle(2);
    queue_transaction(OP_CONV, 8'h00, 1, BITS_ONES);
    queue_transaction(OP_CONV, 8'h00, 0, BITS_ONES);
    queue_transaction(OP_WRREG, 8'h10, 0, BITS_RANDOM);
    queue_transaction(OP_RDREG, 8'hFF, 0, BITS_ZEROS);
    queue_noise(10);

    // Zero half_period, poll_limit and poll_gap behave as one
    load_config(10'd0, 8'd0, 10'd0, 1'b1);
    queue_transaction(OP_CONV, 8'h00, 0, BITS_RANDOM);
    queue_transaction(OP_CONV, 8'h00, 1, BITS_RANDOM);
    queue_transaction(OP_WRREG, 8'hFF, 0, BITS_RANDOM);

    // Longest poll: 255 checks to timeout
    load_config(10'd2, 8'd255, 10'd1, 1'b0);
    queue_transaction(OP_CONV, 8'h00, 255, BITS_RANDOM);

    // Widest clock phase and gap: only a timed-out poll fits the item budget
    load_config(10'd1023, 8'd1, 10'd1023, 1'b0);
    queue_transaction(OP_CONV, 8'h00, 1, BITS_RANDOM);
    queue_idle(2);

    // Random part: mostly well-formed frames with random content under random
    // settings, with some bursts of raw noise in between, up to the budget
    while (ticks_queued < ITEM_BUDGET) begin
      r_hp  = HP_W'(($urandom_range(0, 9) < 8) ? 1 : $urandom_range(0, 2));
      r_lim = POLL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 6));
      r_gap = HP_W'($urandom_range(0, 4));
      load_config(r_hp, r_lim, r_gap, 1'($urandom));
      repeat ($urandom_range(2, 4)) begin
        if (ticks_queued < ITEM_BUDGET) begin
          if ($urandom_range(0, 99) < 85) begin
            queue_transaction(op_t'($urandom_range(1, 3)), 8'($urandom),
                              $urandom_range(0, at_least_one(limit_reg)),
                              bits_t'($urandom_range(0, 2)));
          end else begin
            queue_noise($urandom_range(1, 12));
          end
          queue_idle($urandom_range(0, 3));
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
